[hdl/acpeq_pkg.sv]
`default_nettype none

package acpeq_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int HIST_W = 5;
    localparam int CNT_W  = 8;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_CALIB = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;
    localparam logic [1:0] MODE_ERROR = 2'd3;

    localparam logic REG_TIMEOUT    = 1'b0;
    localparam logic REG_MIN_PERIOD = 1'b1;

    localparam logic [CNT_W-1:0] TIMEOUT_RST    = 8'd102;
    localparam logic [CNT_W-1:0] MIN_PERIOD_RST = 8'd97;
    localparam logic [CNT_W-1:0] TICK_RST       = 8'd254;
    localparam logic [CNT_W-1:0] CNT_FULL       = 8'd255;

    typedef struct packed {
        logic [CNT_W-1:0] timeout_ticks;
        logic [CNT_W-1:0] min_period_ticks;
    } acpeq_cfg_t;

    // majority of five
    function automatic logic vote5(input logic [HIST_W-1:0] h);
        logic [2:0] ones;
        ones = 3'd0;
        for (int i = 0; i < HIST_W; i++)
        begin
            ones = ones + {2'b00, h[i]};
        end
        return (ones >= 3'd3);
    endfunction

endpackage

`default_nettype wire

[hdl/acpeq_if.sv]
`default_nettype none

interface acpeq_in_if
    import acpeq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic              sample;
    logic [HIST_W-1:0] start_history;

    modport source (output valid, func, sample, start_history, input ready);
    modport sink (input valid, func, sample, start_history, output ready);
endinterface

interface acpeq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       filtered_level;
    logic       phase_edge;

    modport source (output valid, status, filtered_level, phase_edge, input ready);
    modport sink (input valid, status, filtered_level, phase_edge, output ready);
endinterface

`default_nettype wire

[hdl/acpeq_cfg.sv]
`default_nettype none

module acpeq_cfg
    import acpeq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output acpeq_cfg_t             cfg
);

    acpeq_cfg_t cfg_reg;
    logic       reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks    <= TIMEOUT_RST;
            cfg_reg.min_period_ticks <= MIN_PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_TIMEOUT:    cfg_reg.timeout_ticks    <= pwdata[CNT_W-1:0];
                REG_MIN_PERIOD: cfg_reg.min_period_ticks <= pwdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TIMEOUT:    prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.timeout_ticks};
            REG_MIN_PERIOD: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.min_period_ticks};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/acpeq_core.sv]
`default_nettype none

module acpeq_core
    import acpeq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire acpeq_cfg_t  cfg,
    acpeq_in_if.sink         item,
    acpeq_out_if.source      result
);

    // input stage
    logic              s1_valid_reg;
    logic              s1_func_reg;
    logic              s1_sample_reg;
    logic [HIST_W-1:0] s1_start_reg;

    // qualifier state
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic              level_reg, level_next;
    logic [1:0]        mode_reg, mode_next;
    logic [CNT_W-1:0]  tick_reg, tick_next;
    logic [CNT_W-1:0]  err_reg, err_next;
    logic [CNT_W-1:0]  rec_reg, rec_next;
    logic              pulse;

    // result stage
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic       out_level_reg;
    logic       out_edge_reg;

    logic              advance;
    logic [HIST_W-1:0] shifted;
    logic              lvl;
    logic [CNT_W-1:0]  err_dec;
    logic [CNT_W-1:0]  rec_dec;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_func_reg   <= item.func;
            s1_sample_reg <= item.sample;
            s1_start_reg  <= item.start_history;
        end
    end

    assign shifted = {hist_reg[HIST_W-2:0], s1_sample_reg};
    assign lvl     = vote5(shifted);
    assign err_dec = err_reg - 8'd1;
    assign rec_dec = rec_reg - 8'd1;

    always_comb
    begin
        hist_next  = hist_reg;
        level_next = level_reg;
        mode_next  = mode_reg;
        tick_next  = tick_reg;
        err_next   = err_reg;
        rec_next   = rec_reg;
        pulse      = 1'b0;
        if (!s1_func_reg)
        begin
            hist_next  = s1_start_reg;
            level_next = vote5(s1_start_reg);
            mode_next  = MODE_CALIB;
            tick_next  = TICK_RST;
            err_next   = CNT_FULL;
            rec_next   = CNT_FULL;
        end
        else if (mode_reg != MODE_IDLE)
        begin
            hist_next = shifted;
            if (lvl == level_reg)
            begin
                if (tick_reg < cfg.timeout_ticks)
                begin
                    tick_next = tick_reg + 8'd1;
                end
                else
                begin
                    tick_next = '0;
                    rec_next  = CNT_FULL;
                    err_next  = err_dec;
                    if (err_dec == '0)
                    begin
                        mode_next = MODE_ERROR;
                    end
                end
            end
            else
            begin
                level_next = lvl;
                tick_next  = '0;
                if (mode_reg == MODE_CALIB)
                begin
                    mode_next = MODE_READY;
                end
                else if (tick_reg > cfg.min_period_ticks)
                begin
                    err_next = CNT_FULL;
                    pulse    = (mode_reg == MODE_READY);
                    rec_next = rec_dec;
                    if (rec_dec == '0)
                    begin
                        mode_next = MODE_READY;
                    end
                end
                else
                begin
                    rec_next = CNT_FULL;
                    err_next = err_dec;
                    if (err_dec == '0)
                    begin
                        mode_next = MODE_ERROR;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            level_reg <= 1'b0;
            mode_reg  <= MODE_IDLE;
            tick_reg  <= TICK_RST;
            err_reg   <= CNT_FULL;
            rec_reg   <= CNT_FULL;
        end
        else if (advance)
        begin
            hist_reg  <= hist_next;
            level_reg <= level_next;
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            err_reg   <= err_next;
            rec_reg   <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= mode_next;
            out_level_reg  <= level_next;
            out_edge_reg   <= pulse;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.filtered_level = out_level_reg;
    assign result.phase_edge     = out_edge_reg;

    a_edge_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_edge_reg |-> out_status_reg == MODE_READY)
        else $error("phase edge outside ready");

    a_start_calib: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !s1_func_reg |=> out_status_reg == MODE_CALIB && !out_edge_reg)
        else $error("start beat did not enter calibration");

    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> tick_reg == TICK_RST && err_reg == CNT_FULL
            && rec_reg == CNT_FULL)
        else $error("counters moved while idle");

    a_status_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_status_reg == mode_reg && out_level_reg == level_reg)
        else $error("result out of step with state");

endmodule

`default_nettype wire

[hdl/ac_phase_edge_qualifier.sv]
// AC phase edge qualifier. Each beat on item is either a start (func 0), which loads the
// five-sample history and enters calibration, or a tick (func 1), which, unless the block
// is idle, shifts in one pin sample, votes the filtered level and updates the timeout, error
// and recovery counters. Every accepted beat yields exactly one result beat carrying status,
// filtered level and the phase edge pulse. One beat is accepted per clock while the result
// side is not stalling; a beat is held in the input register on acceptance and the state
// update then loads the result register, from which the result beat is offered. The state
// update loop sets that rate. Two APB registers: timeout_ticks at 0x0 and min_period_ticks
// at 0x4, to be written only while no beat is in flight.
`default_nettype none

module ac_phase_edge_qualifier
    import acpeq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    acpeq_in_if.sink               item,
    acpeq_out_if.source            result
);

    acpeq_cfg_t cfg;

    acpeq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acpeq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
    import acpeq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] status;
        logic       level;
        logic       pulse;
    } phase_result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    acpeq_in_if  item_if ();
    acpeq_out_if result_if ();

    ac_phase_edge_qualifier uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_if),
        .result  (result_if)
    );

    // qualifier state as the block should hold it
    logic [HIST_W-1:0] pin_history;
    logic              level_now;
    logic [1:0]        mode_now;
    logic [CNT_W-1:0]  tick_now;
    logic [CNT_W-1:0]  error_left;
    logic [CNT_W-1:0]  recover_left;
    logic [CNT_W-1:0]  cfg_timeout;
    logic [CNT_W-1:0]  cfg_min_period;

    phase_result_t pending_results[$];
    int unsigned   fail_count  = 0;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left  = 0;
    bit            traffic_gaps;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned gap_length();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic majority(input logic [HIST_W-1:0] h);
        return $countones(h) >= 3;
    endfunction

    function automatic void count_fault();
        recover_left = CNT_FULL;
        error_left   = error_left - 1'b1;
        if (error_left == '0)
            mode_now = MODE_ERROR;
    endfunction

    function automatic void advance_qualifier(input logic fn, input logic pin,
                                              input logic [HIST_W-1:0] hist);
        phase_result_t r;
        logic          lvl;
        r.pulse = 1'b0;
        if (fn == 1'b0)
        begin
            pin_history  = hist;
            level_now    = majority(hist);
            mode_now     = MODE_CALIB;
            tick_now     = TICK_RST;
            error_left   = CNT_FULL;
            recover_left = CNT_FULL;
        end
        else if (mode_now != MODE_IDLE)
        begin
            pin_history = {pin_history[HIST_W-2:0], pin};
            lvl = majority(pin_history);
            if (lvl == level_now)
            begin
                if (tick_now < cfg_timeout)
                    tick_now = tick_now + 1'b1;
                else
                begin
                    tick_now = '0;
                    count_fault();
                end
            end
            else
            begin
                level_now = lvl;
                if (mode_now == MODE_CALIB)
                    mode_now = MODE_READY;
                else if (tick_now > cfg_min_period)
                begin
                    error_left = CNT_FULL;
                    if (mode_now == MODE_READY)
                        r.pulse = 1'b1;
                    recover_left = recover_left - 1'b1;
                    if (recover_left == '0)
                        mode_now = MODE_READY;
                end
                else
                    count_fault();
                tick_now = '0;
            end
        end
        r.status = mode_now;
        r.level  = level_now;
        pending_results.push_back(r);
    endfunction

    // result side: random back-pressure
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready = 1'b1;
                if (traffic_gaps && $urandom_range(0, 99) < 30)
                    stall_left = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        phase_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result_if.status);
                    fail_count++;
                end
                if (result_if.filtered_level !== want.level)
                begin
                    $error("filtered_level: expected %0d, got %0d", want.level,
                           result_if.filtered_level);
                    fail_count++;
                end
                if (result_if.phase_edge !== want.pulse)
                begin
                    $error("phase_edge: expected %0d, got %0d", want.pulse,
                           result_if.phase_edge);
                    fail_count++;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic fn, input logic pin, input logic [HIST_W-1:0] hist);
        int unsigned gap;
        gap = 0;
        if (traffic_gaps && $urandom_range(0, 99) < 35)
            gap = gap_length();
        if (gap > 0)
        begin
            item_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid         = 1'b1;
        item_if.func          = fn;
        item_if.sample        = pin;
        item_if.start_history = hist;
        do
            @(posedge clk);
        while (!item_if.ready);
        advance_qualifier(fn, pin, hist);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        item_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] value);
        wait_results_drained();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_TIMEOUT)
            cfg_timeout = value;
        else
            cfg_min_period = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] timeout, input logic [CNT_W-1:0] min_p);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_MIN_PERIOD, min_p);
    endtask

    // runs of one level with noise, restarts and stray samples mixed in
    task automatic run_sequence(input int unsigned count, input int unsigned max_run);
        logic        target;
        int unsigned run_left;
        int unsigned r;
        target = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, max_run);
        send_item(1'b0, 1'($urandom_range(0, 1)), HIST_W'($urandom));
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(1'b0, 1'($urandom_range(0, 1)), HIST_W'($urandom));
            else if (r < 10)
                send_item(1'b1, 1'($urandom_range(0, 1)), HIST_W'($urandom));
            else
            begin
                send_item(1'b1, target, HIST_W'($urandom));
                run_left--;
                if (run_left == 0)
                begin
                    target = ~target;
                    run_left = $urandom_range(1, max_run);
                end
            end
        end
    endtask

    task automatic test_idle_ticks();
        send_item(1'b1, 1'b0, 5'h1F);
        send_item(1'b1, 1'b1, 5'h00);
    endtask

    task automatic test_calibration_and_edges();
        send_item(1'b0, 1'b1, 5'h1F);
        send_item(1'b0, 1'b0, 5'h00);
        // first level change leaves calibration
        repeat (3) send_item(1'b1, 1'b1, 5'h1F);
        repeat (2) send_item(1'b1, 1'b1, 5'h00);
        // early edge in ready
        repeat (3) send_item(1'b1, 1'b0, 5'h15);
        send_item(1'b0, 1'b0, 5'b01011);
        send_item(1'b1, 1'b0, 5'h0A);
        send_item(1'b0, 1'b1, 5'b10100);
        send_item(1'b1, 1'b1, 5'h1F);
    endtask

    task automatic test_random_settings();
        logic [CNT_W-1:0] timeout;
        logic [CNT_W-1:0] min_p;
        int unsigned      max_run;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       begin timeout = 8'd0;   min_p = 8'd0;   max_run = 6;  end
                1:       begin timeout = 8'd255; min_p = 8'd255; max_run = 12; end
                2:       begin timeout = 8'd0;   min_p = 8'd255; max_run = 8;  end
                3:       begin timeout = 8'd255; min_p = 8'd0;   max_run = 8;  end
                5:
                begin
                    timeout = CNT_W'($urandom);
                    min_p   = CNT_W'($urandom);
                    max_run = 20;
                end
                default:
                begin
                    timeout = CNT_W'($urandom_range(0, 15));
                    min_p   = CNT_W'($urandom_range(0, 8));
                    max_run = $urandom_range(3, 20);
                end
            endcase
            traffic_gaps = (phase % 3) != 2;
            set_limits(timeout, min_p);
            run_sequence(9, max_run);
        end
        traffic_gaps = 1'b1;
    endtask

    task automatic test_error_and_recovery();
        // with both limits at zero every tick counts a fault, walking the error count down to MODE_ERROR and past zero
        set_limits(8'd0, 8'd0);
        send_item(1'b0, 1'b0, 5'h00);
        repeat (258) send_item(1'b1, 1'b0, HIST_W'($urandom));
        // an edge every second tick, each one good, until recovery completes
        set_limits(8'd255, 8'd0);
        traffic_gaps = 1'b0;
        for (int k = 0; k < 530; k++)
            send_item(1'b1, (k % 4) < 2, HIST_W'($urandom));
        traffic_gaps = 1'b1;
        send_item(1'b0, 1'b1, 5'h1F);
        send_item(1'b1, 1'b0, 5'h00);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_if.valid         = 1'b0;
        item_if.func          = 1'b0;
        item_if.sample        = 1'b0;
        item_if.start_history = '0;
        traffic_gaps          = 1'b1;
        pin_history           = '0;
        level_now             = 1'b0;
        mode_now              = MODE_IDLE;
        tick_now              = TICK_RST;
        error_left            = CNT_FULL;
        recover_left          = CNT_FULL;
        cfg_timeout           = TIMEOUT_RST;
        cfg_min_period        = MIN_PERIOD_RST;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_ticks();
        test_calibration_and_edges();
        test_random_settings();
        test_error_and_recovery();

        wait_results_drained();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
